// File: sv/ptstat_pkg.sv
// Shared types and constants for the period temperature statistics block.
`timescale 1ns / 1ps

package ptstat_pkg;

  // Register indexes on the configuration port (byte address is four times the index).
  localparam logic [1:0] REG_FILTER_YEAR  = 2'd0;
  localparam logic [1:0] REG_FILTER_MONTH = 2'd1;
  localparam logic [1:0] REG_MONTHLY_MODE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] FILTER_YEAR_RST  = 16'd2025;
  localparam logic [3:0]  FILTER_MONTH_RST = 4'd1;

  // Limits of an 8-bit temperature, also the empty-set minimum and maximum.
  localparam logic signed [7:0] TEMP_MAX_C = 8'sd127;
  localparam logic signed [7:0] TEMP_MIN_C = -8'sd128;

  // The mean is given in hundredths of a degree.
  localparam int unsigned MEAN_SCALE = 100;

  // Largest possible mean magnitude in hundredths.
  localparam int unsigned MEAN_MAG_MAX = 12800;

  // Controller states.
  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_SCALE,
    ST_DIV,
    ST_ROUND,
    ST_LOAD
  } ptstat_state_e;

  // Filter settings handed to the datapath.
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic        monthly;
  } ptstat_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic scale;
    logic div_step;
    logic round;
    logic load;
  } ptstat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_req;
    logic snap_zero;
    logic div_done;
    logic out_free;
  } ptstat_status_t;

endpackage

// File: sv/period_temperature_stats_core.sv
// Top level of the period temperature statistics block: register file and instances.
//
// Usage: records enter on the s_axis channel, one request per item; tuser carries
// record_present and tlast marks the final record of a set. Matching records
// (year, and month in monthly mode) update a count, a sum, a minimum and a maximum.
// A request with tlast closes the set and yields one result on the m_axis channel:
// tuser is the no-data status, tdata the count, minimum, maximum and rounded mean.
// Records without tlast are taken one per cycle while tready is high. After a closing
// item tready stays low while the controller steps through its scale, divide, round
// and load states; the restoring divider works on a NumW-bit numerator (NumW =
// clog2(RECORD_CAPACITY + 1) + 14, so 25 with the default capacity) and yields one
// quotient bit per cycle. A set with no match skips the divider.
// If the receiver stalls, the result waits in the output register and records of
// the next set are still taken; the next closing item then holds in its final
// stage until the previous result has been taken.
// Reset clears the accumulators, drops m_axis_tvalid and restores the registers
// (filter_year 2025, filter_month 1, monthly_mode 0). The APB registers should be
// written only while the block is idle.
`timescale 1ns / 1ps

module period_temperature_stats_core
  import ptstat_pkg::*;
#(
  parameter int unsigned RECORD_CAPACITY = 1024,
  localparam int unsigned CntW = $clog2(RECORD_CAPACITY + 1),
  localparam int unsigned OutDataW = ((CntW + 31 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Record channel.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata, lowest bit up: rec_year[15:0], rec_month[19:16], rec_temp[27:20], zeros.
  input  logic [31:0]         s_axis_tdata,
  // tuser: record_present.
  input  logic                s_axis_tuser,
  input  logic                s_axis_tlast,
  // Result channel.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata, lowest bit up: match_count, temp_min, temp_max, temp_mean, zeros.
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: status.
  output logic                m_axis_tuser
);

  ptstat_cfg_t    cfg_q;
  ptstat_cmd_t    cmd;
  ptstat_status_t status;
  logic           cfg_wr;

  logic [CntW-1:0]      out_count;
  logic signed [7:0]    out_min;
  logic signed [7:0]    out_max;
  logic signed [14:0]   out_mean;

  // Configuration registers, written in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.year    <= FILTER_YEAR_RST;
      cfg_q.month   <= FILTER_MONTH_RST;
      cfg_q.monthly <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FILTER_YEAR:  cfg_q.year    <= pwdata[15:0];
        REG_FILTER_MONTH: cfg_q.month   <= pwdata[3:0];
        REG_MONTHLY_MODE: cfg_q.monthly <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_FILTER_YEAR:  prdata = {16'd0, cfg_q.year};
      REG_FILTER_MONTH: prdata = {28'd0, cfg_q.month};
      REG_MONTHLY_MODE: prdata = {31'd0, cfg_q.monthly};
      default:          prdata = '0;
    endcase
  end

  // Controller.
  ptstat_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Datapath.
  ptstat_datapath #(
    .RECORD_CAPACITY (RECORD_CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_valid_i   (s_axis_tvalid),
    .in_present_i (s_axis_tuser),
    .in_year_i    (s_axis_tdata[15:0]),
    .in_month_i   (s_axis_tdata[19:16]),
    .in_temp_i    ($signed(s_axis_tdata[27:20])),
    .in_last_i    (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_count_o  (out_count),
    .out_min_o    (out_min),
    .out_max_o    (out_max),
    .out_mean_o   (out_mean)
  );

  assign s_axis_tready = cmd.in_ready;

  // Result packing, zero-filled to whole bytes.
  assign m_axis_tdata = OutDataW'({out_mean, out_max, out_min, out_count});

endmodule

// File: sv/ptstat_ctrl.sv
// Controller state machine of the period temperature statistics block.
`timescale 1ns / 1ps

module ptstat_ctrl
  import ptstat_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ptstat_status_t status_i,
  output ptstat_cmd_t    cmd_o
);

  ptstat_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a closing request starts the mean calculation.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACCUM: begin
        if (status_i.last_req) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (status_i.snap_zero) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          state_d = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  // Command outputs decoded from the current state; the load also waits for out_free.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_ACCUM: cmd_o.in_ready = 1'b1;
      ST_SCALE: cmd_o.scale    = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_ROUND: cmd_o.round    = 1'b1;
      ST_LOAD:  cmd_o.load     = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

// File: sv/ptstat_datapath.sv
// Datapath: filter, accumulators, mean divider and result register.
`timescale 1ns / 1ps

module ptstat_datapath
  import ptstat_pkg::*;
#(
  parameter int unsigned RECORD_CAPACITY = 1024,
  localparam int unsigned CntW = $clog2(RECORD_CAPACITY + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ptstat_cfg_t            cfg_i,
  input  ptstat_cmd_t            cmd_i,
  output ptstat_status_t         status_o,
  input  logic                   in_valid_i,
  input  logic                   in_present_i,
  input  logic [15:0]            in_year_i,
  input  logic [3:0]             in_month_i,
  input  logic signed [7:0]      in_temp_i,
  input  logic                   in_last_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_status_o,
  output logic [CntW-1:0]        out_count_o,
  output logic signed [7:0]      out_min_o,
  output logic signed [7:0]      out_max_o,
  output logic signed [14:0]     out_mean_o
);

  // Sum needs the eight bits of a temperature plus the count bits; the magnitude drops the sign.
  localparam int unsigned SumW = CntW + 8;
  localparam int unsigned MagW = SumW - 1;
  localparam int unsigned NumW = MagW + 7;
  localparam int unsigned IterW = $clog2(NumW);

  logic [CntW-1:0]          cnt_q;
  logic signed [SumW-1:0]   sum_q;
  logic signed [7:0]        min_q;
  logic signed [7:0]        max_q;

  logic [CntW-1:0]          cnt_n;
  logic signed [SumW-1:0]   sum_n;
  logic signed [7:0]        min_n;
  logic signed [7:0]        max_n;
  logic                     accept;
  logic                     hit;

  logic [CntW-1:0]          s_cnt_q;
  logic signed [7:0]        s_min_q;
  logic signed [7:0]        s_max_q;
  logic                     s_neg_q;
  logic [MagW-1:0]          s_mag_q;
  logic [SumW-1:0]          sum_abs;

  logic [NumW-1:0]          num_q;
  logic [CntW-1:0]          rem_q;
  logic [IterW-1:0]         iter_q;
  logic [CntW:0]            rem_sh;
  logic [CntW:0]            rem_diff;
  logic                     q_bit;

  logic [CntW:0]            twice;
  logic                     round_up;
  logic [14:0]              q_rnd;
  logic signed [14:0]       mean_q;

  logic                     out_valid_q;

  // Filter test and the accumulator values after this request.
  always_comb begin
    accept = in_valid_i && cmd_i.in_ready;
    hit = in_present_i && (in_year_i == cfg_i.year) &&
          (!cfg_i.monthly || (in_month_i == cfg_i.month)) &&
          (cnt_q < CntW'(RECORD_CAPACITY));
    cnt_n = cnt_q;
    sum_n = sum_q;
    min_n = min_q;
    max_n = max_q;
    if (hit) begin
      cnt_n = cnt_q + CntW'(1);
      sum_n = sum_q + SumW'(in_temp_i);
      if (in_temp_i < min_q) begin
        min_n = in_temp_i;
      end
      if (in_temp_i > max_q) begin
        max_n = in_temp_i;
      end
    end
    sum_abs = (sum_n < 0) ? SumW'(-sum_n) : SumW'(sum_n);
  end

  // Accumulators clear when a set closes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      min_q <= TEMP_MAX_C;
      max_q <= TEMP_MIN_C;
    end else if (accept) begin
      if (in_last_i) begin
        cnt_q <= '0;
        sum_q <= '0;
        min_q <= TEMP_MAX_C;
        max_q <= TEMP_MIN_C;
      end else begin
        cnt_q <= cnt_n;
        sum_q <= sum_n;
        min_q <= min_n;
        max_q <= max_n;
      end
    end
  end

  // Snapshot of the closed set for the mean calculation.
  always_ff @(posedge clk_i) begin
    if (accept && in_last_i) begin
      s_cnt_q <= cnt_n;
      s_min_q <= min_n;
      s_max_q <= max_n;
      s_neg_q <= (sum_n < 0);
      s_mag_q <= sum_abs[MagW-1:0];
    end
  end

  // One restoring division step per cycle: a quotient bit shifts in as a numerator bit leaves.
  always_comb begin
    rem_sh   = {rem_q, num_q[NumW-1]};
    rem_diff = rem_sh - {1'b0, s_cnt_q};
    q_bit    = (rem_sh >= {1'b0, s_cnt_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      num_q  <= NumW'(s_mag_q) * NumW'(MEAN_SCALE);
      rem_q  <= '0;
      iter_q <= IterW'(NumW - 1);
    end else if (cmd_i.div_step) begin
      num_q  <= {num_q[NumW-2:0], q_bit};
      rem_q  <= q_bit ? rem_diff[CntW-1:0] : rem_sh[CntW-1:0];
      iter_q <= iter_q - IterW'(1);
    end
  end

  // Round to nearest, ties to even, then restore the sign.
  always_comb begin
    twice    = {rem_q, 1'b0};
    round_up = (twice > {1'b0, s_cnt_q}) || ((twice == {1'b0, s_cnt_q}) && num_q[0]);
    q_rnd    = {1'b0, num_q[13:0]} + {14'd0, round_up};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      mean_q <= s_neg_q ? $signed(~q_rnd + 15'd1) : $signed(q_rnd);
    end
  end

  // Result register; it holds until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_status_o <= (s_cnt_q == '0);
      out_count_o  <= s_cnt_q;
      out_min_o    <= s_min_q;
      out_max_o    <= s_max_q;
      out_mean_o   <= (s_cnt_q == '0) ? 15'sd0 : mean_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status back to the controller.
  always_comb begin
    status_o.last_req  = accept && in_last_i;
    status_o.snap_zero = (s_cnt_q == '0);
    status_o.div_done  = (iter_q == '0);
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  // The count never passes the capacity.
  a_cnt_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RECORD_CAPACITY))
    else $error("match count beyond capacity");

  // A closing request leaves the accumulators cleared.
  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (cnt_q == '0) && (sum_q == '0) &&
    (min_q == TEMP_MAX_C) && (max_q == TEMP_MIN_C))
    else $error("accumulators not cleared after a closing request");

  // A loaded result is offered in the next cycle.
  a_load_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> out_valid_q)
    else $error("loaded result not offered");

  // A load never overwrites a result that is still waiting.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  // The rounded quotient stays within the range of the mean.
  a_mean_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round |-> (q_rnd <= 15'(MEAN_MAG_MAX)))
    else $error("mean magnitude out of range");

endmodule
